@@ design/dictionary_bit_pack_encoder_unit_defines.svh @@
// Assertion macros for the dictionary bit-pack encoder.
// Included by the modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef DICTIONARY_BIT_PACK_ENCODER_UNIT_DEFINES_SVH
`define DICTIONARY_BIT_PACK_ENCODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DBPE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DBPE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DBPE_ASSERT(lbl, prop, msg)
`define DBPE_NEVER(lbl, cond, msg)
`endif
`endif

@@ design/dbpe_pkg.sv @@
// Shared types and constants of the dictionary bit-pack encoder.
// No dependencies.
package dbpe_pkg;
	localparam int CHUNK_DEPTH = 4096;
	localparam int MAX_CLASSES = 16;
	localparam int ADDR_W = $clog2(CHUNK_DEPTH);
	localparam int LEN_W = $clog2(CHUNK_DEPTH + 1);
	localparam int EMIT_W = LEN_W + 1;
	localparam int WIDE_W = EMIT_W + 3;
	localparam int CLS_W = $clog2(MAX_CLASSES);
	localparam int IQ_DEPTH = 4;
	localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
	localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVER = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       chunk_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_final;
		logic [1:0] status;
		logic [8:0] distinct_count;
	} out_item_t;

	typedef enum logic [1:0] {CMD_LOAD, CMD_LAST, CMD_PULL} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data;
	} cmd_item_t;

	typedef enum logic [1:0] {PH_LOADING, PH_EMITTING, PH_FAILED, PH_DONE} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_SCAN, BK_CLOSE, BK_COPY_WAIT, BK_PACK_RD, BK_PACK_WAIT
	} bk_state_t;
endpackage

@@ design/dbpe_front.sv @@
// Front part: input queue that accepts items and classifies them into commands.
// Depends on dbpe_pkg.
module dbpe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  dbpe_pkg::in_item_t  item,
	output logic                cmd_valid,
	output dbpe_pkg::cmd_item_t cmd_item,
	input  logic                cmd_take
);
	import dbpe_pkg::*;

	cmd_item_t             q_q [IQ_DEPTH];
	logic [IQ_PTR_W-1:0]   wptr_q, rptr_q;
	logic [IQ_CNT_W-1:0]   cnt_q;
	cmd_item_t             cls;
	logic                  wr, rd;

	always_comb begin
		cls.data = item.data_byte;
		unique case ({item.action, item.chunk_end})
			2'b00: cls.cmd = CMD_LOAD;
			2'b01: cls.cmd = CMD_LAST;
			default: cls.cmd = CMD_PULL;
		endcase
	end

	assign full = (cnt_q == IQ_CNT_W'(IQ_DEPTH));
	assign wr = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign rd = cmd_take && cmd_valid;
	assign cmd_item = q_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + IQ_CNT_W'(wr) - IQ_CNT_W'(rd);
		end
	end
endmodule

@@ design/dbpe_back.sv @@
// Back part: chunk memory, presence map, dictionary build and byte emission,
// with a two-entry result queue. Depends on dbpe_pkg and the defines header.
`include "dictionary_bit_pack_encoder_unit_defines.svh"
module dbpe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  dbpe_pkg::cmd_item_t cmd_item,
	output logic                cmd_take,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_data,
	output logic                empty,
	input  logic                pop,
	output dbpe_pkg::out_item_t result
);
	import dbpe_pkg::*;

	logic [7:0]        mem [CHUNK_DEPTH];
	logic [7:0]        rd_q;
	logic [ADDR_W-1:0] rd_addr;

	bk_state_t         state_q, state_d;
	phase_t            phase_q;
	logic [255:0]      present_q;
	logic [7:0]        dict_q [MAX_CLASSES];
	logic [8:0]        n_q;
	logic [LEN_W-1:0]  len_q;
	logic [EMIT_W-1:0] emit_pos_q, emit_total_q;
	logic [2:0]        pw_q;
	logic [3:0]        bpv_q;
	logic [7:0]        scan_q;
	logic [LEN_W:0]    elem_q;
	logic [2:0]        j_q;
	logic [7:0]        acc_q;

	out_item_t         rq_q [2];
	logic              rq_w_q, rq_r_q;
	logic [1:0]        rq_cnt_q;

	logic              res_we;
	out_item_t         res_d;
	logic              restart, store, advance;
	logic [LEN_W-1:0]  eff_len;
	logic [EMIT_W-1:0] pos_next;
	logic              fin;
	logic [WIDE_W-1:0] p_wide, first_wide;
	logic [CLS_W-1:0]  idx;
	logic [7:0]        acc_new;
	logic [2:0]        last_j;
	logic              pack_mode, failed;
	logic [4:0]        limit;
	logic [WIDE_W-1:0] packed_len, tot;

	assign pos_next = emit_pos_q + 1'b1;
	assign fin = (pos_next >= emit_total_q);
	assign restart = (phase_q != PH_LOADING);
	assign eff_len = restart ? '0 : len_q;
	assign store = (eff_len < LEN_W'(CHUNK_DEPTH));
	assign last_j = (pw_q == 3'd1) ? 3'd7 : (pw_q == 3'd2) ? 3'd3 : 3'd1;
	assign p_wide = WIDE_W'(emit_pos_q) - WIDE_W'(n_q) - WIDE_W'(1);
	assign first_wide = (pw_q == 3'd1) ? (p_wide << 3) :
		(pw_q == 3'd2) ? (p_wide << 2) : (p_wide << 1);

	// Dictionary lookup of the byte just read; the lowest matching slot wins.
	always_comb begin
		idx = '0;
		for (int i = MAX_CLASSES - 1; i >= 0; i--) begin
			if (9'(i) < n_q && dict_q[i] == rd_q) begin
				idx = CLS_W'(i);
			end
		end
	end
	assign acc_new = (elem_q < (LEN_W + 1)'(len_q)) ? 8'((acc_q << pw_q) | 8'(idx))
		: 8'(acc_q << pw_q);

	// Chunk close: class limit and total output length.
	assign pack_mode = (bpv_q == 4'd1) || (bpv_q == 4'd2) || (bpv_q == 4'd4);
	always_comb begin
		limit = (bpv_q == 4'd1) ? 5'd2 : (bpv_q == 4'd2) ? 5'd4 : 5'd16;
		if (limit > 5'(MAX_CLASSES)) begin
			limit = 5'(MAX_CLASSES);
		end
		failed = pack_mode && (n_q > 9'(limit));
		packed_len = ((WIDE_W'(len_q) << ((bpv_q == 4'd1) ? 0 : (bpv_q == 4'd2) ? 1 : 2))
			+ WIDE_W'(7)) >> 3;
		tot = WIDE_W'(1) + WIDE_W'(n_q) + packed_len;
		if (tot < WIDE_W'(len_q)) begin
			tot = WIDE_W'(len_q);
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_take = 1'b0;
		res_we = 1'b0;
		advance = 1'b0;
		res_d.out_byte = 8'd0;
		res_d.out_final = 1'b0;
		res_d.status = ST_OK;
		res_d.distinct_count = n_q;
		rd_addr = emit_pos_q[ADDR_W-1:0];
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && rq_cnt_q != 2'd2) begin
					cmd_take = 1'b1;
					unique case (cmd_item.cmd)
						CMD_LOAD: begin
							res_we = 1'b1;
							res_d.distinct_count = '0;
						end
						CMD_LAST: state_d = BK_SCAN;
						default: begin
							if (phase_q == PH_EMITTING) begin
								if (pw_q == 3'd0) begin
									state_d = BK_COPY_WAIT;
								end else if (emit_pos_q == '0) begin
									res_we = 1'b1;
									advance = 1'b1;
									res_d.out_byte = n_q[7:0];
								end else if (EMIT_W'(n_q) >= emit_pos_q) begin
									res_we = 1'b1;
									advance = 1'b1;
									res_d.out_byte = dict_q[CLS_W'(emit_pos_q - 1'b1)];
								end else if (first_wide >= WIDE_W'(len_q)) begin
									res_we = 1'b1;
									advance = 1'b1;
								end else begin
									state_d = BK_PACK_RD;
								end
							end else begin
								res_we = 1'b1;
								res_d.status = (phase_q == PH_FAILED) ? ST_OVER : ST_EMPTY;
							end
						end
					endcase
				end
			end
			BK_SCAN: begin
				if (scan_q == 8'd255) begin
					state_d = BK_CLOSE;
				end
			end
			BK_CLOSE: begin
				res_we = 1'b1;
				res_d.status = failed ? ST_OVER : ST_OK;
				state_d = BK_IDLE;
			end
			BK_COPY_WAIT: begin
				res_we = 1'b1;
				advance = 1'b1;
				res_d.out_byte = rd_q;
				state_d = BK_IDLE;
			end
			BK_PACK_RD: begin
				rd_addr = elem_q[ADDR_W-1:0];
				state_d = BK_PACK_WAIT;
			end
			BK_PACK_WAIT: begin
				if (j_q == last_j) begin
					res_we = 1'b1;
					advance = 1'b1;
					res_d.out_byte = acc_new;
					state_d = BK_IDLE;
				end else begin
					state_d = BK_PACK_RD;
				end
			end
			default: state_d = BK_IDLE;
		endcase
		if (advance) begin
			res_d.out_final = fin;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && cmd_take && cmd_item.cmd != CMD_PULL && store) begin
			mem[eff_len[ADDR_W-1:0]] <= cmd_item.data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			rq_q[rq_w_q] <= res_d;
		end
		if (state_q == BK_SCAN && present_q[scan_q] && n_q < 9'(MAX_CLASSES)) begin
			dict_q[n_q[CLS_W-1:0]] <= scan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOADING;
			present_q <= '0;
			n_q <= '0;
			len_q <= '0;
			emit_pos_q <= '0;
			emit_total_q <= '0;
			pw_q <= '0;
			bpv_q <= 4'd8;
			scan_q <= '0;
			elem_q <= '0;
			j_q <= '0;
			acc_q <= '0;
			rq_w_q <= 1'b0;
			rq_r_q <= 1'b0;
			rq_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				bpv_q <= cfg_data;
			end
			if (state_q == BK_IDLE && cmd_take && cmd_item.cmd != CMD_PULL) begin
				if (restart) begin
					n_q <= '0;
					emit_pos_q <= '0;
					emit_total_q <= '0;
					pw_q <= '0;
					phase_q <= PH_LOADING;
				end
				// A new chunk starts from an empty map and marks its first byte at once.
				if (store) begin
					present_q <= (restart ? 256'd0 : present_q) | (256'd1 << cmd_item.data);
					len_q <= eff_len + 1'b1;
				end else begin
					len_q <= eff_len;
				end
				scan_q <= '0;
			end
			if (state_q == BK_IDLE && state_d == BK_PACK_RD) begin
				elem_q <= first_wide[LEN_W:0];
				j_q <= '0;
				acc_q <= '0;
			end
			if (state_q == BK_SCAN) begin
				scan_q <= scan_q + 1'b1;
				if (present_q[scan_q]) begin
					n_q <= n_q + 1'b1;
				end
			end
			if (state_q == BK_CLOSE) begin
				emit_pos_q <= '0;
				if (failed) begin
					phase_q <= PH_FAILED;
					pw_q <= '0;
					emit_total_q <= '0;
				end else begin
					phase_q <= PH_EMITTING;
					pw_q <= pack_mode ? bpv_q[2:0] : 3'd0;
					emit_total_q <= pack_mode ? tot[EMIT_W-1:0] : EMIT_W'(len_q);
				end
			end
			if (state_q == BK_PACK_WAIT) begin
				acc_q <= acc_new;
				j_q <= j_q + 1'b1;
				elem_q <= elem_q + 1'b1;
			end
			if (advance) begin
				emit_pos_q <= pos_next;
				if (fin) begin
					phase_q <= PH_DONE;
				end
			end
			if (res_we) begin
				rq_w_q <= ~rq_w_q;
			end
			if (pop && !empty) begin
				rq_r_q <= ~rq_r_q;
			end
			rq_cnt_q <= rq_cnt_q + 2'(res_we) - 2'(pop && !empty);
		end
	end

	assign empty = (rq_cnt_q == 2'd0);
	assign result = rq_q[rq_r_q];

	`DBPE_NEVER(a_rq_overflow, res_we && rq_cnt_q == 2'd2 && !pop, "result queue overflow")
	`DBPE_ASSERT(a_pack_width, (state_q == BK_PACK_RD) |-> (pw_q != 3'd0), "packing with zero width")
	`DBPE_ASSERT(a_final_done, (res_we && res_d.out_final) |=> (phase_q == PH_DONE), "final without done")
	`DBPE_ASSERT(a_take_idle, cmd_take |-> (state_q == BK_IDLE), "take outside idle")
endmodule

@@ design/dictionary_bit_pack_encoder_unit.sv @@
// Dictionary bit-pack encoder: each pushed item is taken by the back end, and the push that
// closes a chunk adds a scan of the whole presence map and a closing step.
// A pull gives the count and dictionary bytes and the zero bytes past the indices straight
// from registers, reads one memory byte in copy mode, and for widths 1, 2 and 4 reads each
// packed index in turn, through the single read port of the chunk memory. A four-item
// input queue and a two-item result queue let both sides stall on their own.
module dictionary_bit_pack_encoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  dbpe_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output dbpe_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_data
);
	import dbpe_pkg::*;

	logic      cmd_valid, cmd_take;
	cmd_item_t cmd_item;

	dbpe_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.cmd_valid(cmd_valid), .cmd_item(cmd_item), .cmd_take(cmd_take)
	);

	dbpe_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_item(cmd_item),
		.cmd_take(cmd_take), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.empty(empty), .pop(pop), .result(result)
	);
endmodule

@@ test/dbpe_checker.sv @@
// Checker for the dictionary bit-pack encoder: watches the item, result and register ports,
// predicts each result from its own copy of the encoder state and compares them.
// Depends on dbpe_pkg for the item types, status codes and phases.
`timescale 1ns / 100ps

module dbpe_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  dbpe_pkg::in_item_t  item,
	input  logic                empty,
	input  logic                pop,
	input  dbpe_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_data,
	output int                  fail_count,
	output int                  pending
);
	import dbpe_pkg::*;

	logic [7:0] chunk_mem [CHUNK_DEPTH];
	bit         seen [256];
	logic [7:0] dict [MAX_CLASSES];
	int         class_cnt, chunk_len, emit_pos, emit_len, pack_w;
	phase_t     phase;
	logic [3:0] width_reg;
	out_item_t  expected_results [$];
	int         mismatches;

	function automatic void open_chunk();
		foreach (seen[v]) seen[v] = 0;
		class_cnt = 0;
		chunk_len = 0;
		emit_pos = 0;
		emit_len = 0;
		pack_w = 0;
		phase = PH_LOADING;
	endfunction

	function automatic void close_chunk();
		int n, lim, k;
		n = 0;
		k = 0;
		for (int v = 0; v < 256; v++)
			if (seen[v])
				n++;
		class_cnt = n;
		emit_pos = 0;
		if (width_reg == 1 || width_reg == 2 || width_reg == 4) begin
			lim = 1 << width_reg;
			if (lim > MAX_CLASSES)
				lim = MAX_CLASSES;
			if (n > lim) begin
				phase = PH_FAILED;
				return;
			end
			for (int v = 0; v < 256; v++)
				if (seen[v] && k < MAX_CLASSES) begin
					dict[k] = v[7:0];
					k++;
				end
			pack_w = width_reg;
			emit_len = 1 + n + (chunk_len * pack_w + 7) / 8;
			if (emit_len < chunk_len)
				emit_len = chunk_len;
		end else begin
			pack_w = 0;
			emit_len = chunk_len;
		end
		phase = PH_EMITTING;
	endfunction

	function automatic int index_of(logic [7:0] b);
		for (int i = 0; i < class_cnt && i < MAX_CLASSES; i++)
			if (dict[i] == b)
				return i;
		return 0;
	endfunction

	function automatic logic [7:0] encoded_byte(int k);
		int per, first, p;
		logic [7:0] acc;
		acc = 0;
		if (pack_w == 0)
			return (k < chunk_len && k < CHUNK_DEPTH) ? chunk_mem[k] : 8'd0;
		if (k == 0)
			return class_cnt[7:0];
		if (k <= class_cnt)
			return (k - 1 < MAX_CLASSES) ? dict[k - 1] : 8'd0;
		p = k - 1 - class_cnt;
		per = 8 / pack_w;
		first = p * per;
		if (first >= chunk_len)
			return 8'd0;
		// Indices go in most significant first; missing ones at the end stay zero.
		for (int j = 0; j < per; j++)
			if (first + j < chunk_len && first + j < CHUNK_DEPTH)
				acc |= 8'(index_of(chunk_mem[first + j]) << (8 - (j + 1) * pack_w));
		return acc;
	endfunction

	function automatic out_item_t encode_step(in_item_t x);
		out_item_t r;
		r = '0;
		r.status = ST_OK;
		if (!x.action) begin
			if (phase != PH_LOADING)
				open_chunk();
			if (chunk_len < CHUNK_DEPTH) begin
				chunk_mem[chunk_len] = x.data_byte;
				seen[x.data_byte] = 1;
				chunk_len++;
			end
			if (x.chunk_end) begin
				close_chunk();
				if (phase == PH_FAILED)
					r.status = ST_OVER;
			end
		end else if (phase == PH_EMITTING) begin
			r.out_byte = encoded_byte(emit_pos);
			emit_pos++;
			if (emit_pos >= emit_len) begin
				r.out_final = 1'b1;
				phase = PH_DONE;
			end
		end else if (phase == PH_FAILED) begin
			r.status = ST_OVER;
		end else begin
			r.status = ST_EMPTY;
		end
		r.distinct_count = class_cnt[8:0];
		return r;
	endfunction

	task automatic note_mismatch(string field, int exp_v, int got_v);
		fail_count++;
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			width_reg = 4'd8;
			open_chunk();
			expected_results.delete();
			fail_count = 0;
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				width_reg = cfg_data;
			if (push && !full)
				expected_results.push_back(encode_step(item));
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing expected", $time);
				end else begin
					e = expected_results.pop_front();
					if (result.out_byte !== e.out_byte)
						note_mismatch("out_byte", e.out_byte, result.out_byte);
					if (result.out_final !== e.out_final)
						note_mismatch("out_final", e.out_final, result.out_final);
					if (result.status !== e.status)
						note_mismatch("status", e.status, result.status);
					if (result.distinct_count !== e.distinct_count)
						note_mismatch("distinct_count", e.distinct_count,
							result.distinct_count);
				end
			end
			pending = expected_results.size();
		end
	end
endmodule

@@ test/tb_top.sv @@
// Top of the encoder testbench: clock, reset, item and register stimulus, verdict.
// Depends on dbpe_pkg, the encoder unit and dbpe_checker.
`timescale 1ns / 100ps

module tb_top;
	import dbpe_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE = 300;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      push = 0;
	logic      pop = 0;
	logic      full, empty;
	in_item_t  item = '0;
	out_item_t result;
	logic      cfg_we = 0;
	logic [3:0] cfg_data = 4'd8;
	int        fail_count, pending;
	int        send_idle = 0, recv_idle = 0;
	int        cycles = 0;
	bit        hold_req = 0;
	int        hold_left = 0;
	int        sent = 0;

	dictionary_bit_pack_encoder_unit uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	dbpe_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Receiver: random pops, and one long hold-off so the input side backs up.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send(logic act, logic [7:0] d, logic last);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		item <= '{action: act, data_byte: d, chunk_end: last};
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic pull(int n);
		repeat (n)
			send(1'b1, 8'($urandom), 1'($urandom));
	endtask

	task automatic load_chunk(logic [7:0] bytes [$]);
		foreach (bytes[i])
			send(1'b0, bytes[i], i == bytes.size() - 1);
	endtask

	task automatic set_width(logic [3:0] w);
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_data <= w;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// A random chunk drawn from a small pool of values, mostly within the class limit.
	task automatic random_chunk(int w);
		logic [7:0] pool [$];
		logic [7:0] bytes [$];
		int lim, ncls, len;
		lim = (w == 1 || w == 2 || w == 4) ? (1 << w) : 20;
		ncls = ($urandom_range(9) == 0) ? lim + $urandom_range(1, 3) : $urandom_range(1, lim);
		len = ($urandom_range(15) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
		for (int i = 0; i < ncls; i++)
			pool.push_back(8'($urandom));
		for (int i = 0; i < len; i++)
			bytes.push_back(pool[$urandom_range(ncls - 1)]);
		if ($urandom_range(19) == 0)
			pull($urandom_range(1, 2));
		load_chunk(bytes);
		if ($urandom_range(7) == 0)
			pull($urandom_range(0, len));
		else
			pull(len + ncls + 3 + $urandom_range(0, 3));
	endtask

	initial begin
		logic [3:0] widths [$] = '{4'd1, 4'd2, 4'd4, 4'd0, 4'd15, 4'd3, 4'd8};
		int w;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Pull while loading, then a copy of the extreme bytes at the reset width.
		pull(1);
		load_chunk('{8'h00, 8'hFF});
		pull(3);
		set_width(4'd1);
		load_chunk('{8'hA5, 8'h5A, 8'hA5});
		pull(5);
		// Three classes do not fit in one index bit.
		load_chunk('{8'h01, 8'h02, 8'h03});
		pull(2);
		set_width(4'd4);
		load_chunk('{8'h80, 8'h7F, 8'h00, 8'hFF});
		pull(3);
		// A new chunk abandons the remaining output.
		load_chunk('{8'h11});
		pull(3);

		w = 8;
		hold_req = 1;
		while (sent < 900) begin
			if (sent < 330) begin
				send_idle = 32;
				recv_idle = 78;
			end else if (sent < 660) begin
				send_idle = 78;
				recv_idle = 32;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if ($urandom_range(5) == 0) begin
				w = (widths.size() != 0) ? widths.pop_front() : $urandom_range(0, 15);
				set_width(4'(w));
			end
			random_chunk(w);
		end

		load_chunk('{8'h42});
		pull(2);

		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
